@@ rtl/binary_image_horizontal_shear_macros.svh @@
// Assertion macros for the horizontal shear block.
// Used by the top level; clk and rst_n must be in scope where they expand.
`ifndef BINARY_IMAGE_HORIZONTAL_SHEAR_MACROS_SVH
`define BINARY_IMAGE_HORIZONTAL_SHEAR_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define BIHS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");
// Next-cycle implication
`define BIHS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define BIHS_ASSERT_IMP(name, ante, cons)
`define BIHS_ASSERT_NXT(name, ante, cons)
`endif

`endif

@@ rtl/bihs_pkg.sv @@
// Shared types, widths and helpers for the horizontal shear block.
// No dependencies.
`timescale 1ns / 1ps

package bihs_pkg;

    localparam int MAX_WIDTH       = 4096;
    localparam int MAX_HEIGHT      = 4096;
    localparam int COL_W           = 12;
    localparam int ROW_W           = 12;
    localparam int SIZE_W          = 13;
    localparam int SHEAR_W         = 24;
    localparam int ORIGIN_W        = 15;
    localparam int SHEAR_FRAC_BITS = 16;
    localparam int ACC_FRAC        = SHEAR_FRAC_BITS + 1;
    localparam int ACC_W           = 42;
    localparam int SHIFT_W         = ACC_W - ACC_FRAC;
    localparam int MUL_OP_W        = 16;
    localparam int PROD_W          = SHEAR_W + MUL_OP_W;
    localparam int ADDR_W          = COL_W + 1;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHEAR        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND   = 3'd4;

    // input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // cycles the frame-start precompute needs after a register write
    localparam logic [1:0] SETTLE_CYCLES = 2'd3;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'sd1 <<< SHEAR_FRAC_BITS);

    typedef struct packed {
        logic signed [ACC_W-1:0] acc_start;
        logic                    uniform;
    } frame_calc_t;

    // effective size minus one: zero acts as one, above the maximum clamps
    function automatic logic [COL_W-1:0] size_m1(input logic [SIZE_W-1:0] v);
        logic [COL_W-1:0] r;
        if (v == '0)
            r = '0;
        else if (v[SIZE_W-1] && (v[SIZE_W-2:0] != '0))
            r = '1;
        else
            r = COL_W'(v - SIZE_W'(1));
        return r;
    endfunction

endpackage

@@ rtl/bihs_frame_calc.sv @@
// Frame-start precompute: start accumulator and uniform-copy decision.
// Two register stages; depends on bihs_pkg.
`timescale 1ns / 1ps

module bihs_frame_calc
(
    input  logic                                  clk,
    input  logic signed [bihs_pkg::SHEAR_W-1:0]   shear,
    input  logic signed [bihs_pkg::ORIGIN_W-1:0]  origin,
    input  logic        [bihs_pkg::ROW_W-1:0]     h_m1,
    output bihs_pkg::frame_calc_t                 calc
);

    logic signed [bihs_pkg::MUL_OP_W-1:0] first_term;
    logic signed [bihs_pkg::MUL_OP_W-1:0] last_term;
    logic signed [bihs_pkg::PROD_W-1:0]   prod_first_reg;
    logic signed [bihs_pkg::PROD_W-1:0]   prod_last_reg;
    logic signed [bihs_pkg::ACC_W-1:0]    acc_first;
    logic signed [bihs_pkg::ACC_W-1:0]    acc_last;
    bihs_pkg::frame_calc_t                calc_reg;

    // 1 - origin and 2*(h-1) + 1 - origin
    assign first_term = bihs_pkg::MUL_OP_W'(1) - bihs_pkg::MUL_OP_W'(origin);
    assign last_term  = $signed({3'b000, h_m1, 1'b1}) - bihs_pkg::MUL_OP_W'(origin);

    always_ff @(posedge clk)
    begin
        prod_first_reg <= shear * first_term;
        prod_last_reg  <= shear * last_term;
    end

    assign acc_first = bihs_pkg::ACC_W'(prod_first_reg) + bihs_pkg::ACC_HALF;
    assign acc_last  = bihs_pkg::ACC_W'(prod_last_reg) + bihs_pkg::ACC_HALF;

    always_ff @(posedge clk)
    begin
        calc_reg.acc_start <= acc_first;
        calc_reg.uniform   <= (acc_first[bihs_pkg::ACC_W-1:bihs_pkg::ACC_FRAC] ==
                               acc_last[bihs_pkg::ACC_W-1:bihs_pkg::ACC_FRAC]);
    end

    assign calc = calc_reg;

endmodule

@@ rtl/binary_image_horizontal_shear.sv @@
// Horizontal shear of a 1-bit raster image through a ping-pong line store.
// Depends on bihs_pkg, bihs_frame_calc and binary_image_horizontal_shear_macros.svh.
`timescale 1ns / 1ps
`include "binary_image_horizontal_shear_macros.svh"

// Channel   Dir  Transfer when              Payload
// s_axis    in   s_axis_tvalid&tready       tuser=kind, tdata[0]=pixel_in
// m_axis    out  m_axis_tvalid&tready       tdata={row,col,pixel}, tlast=row_end,
//                                           tuser=frame_end
// cfg       in   cfg_we                     cfg_index selects register, cfg_data
//
// One item per cycle sustained; every item, pixel or flush, drains one pixel of
// the pending row through the registered read of the line store.
// The output register is reloaded in the same cycle it is taken, so apart from settling,
// input only stalls when a result is waiting and the output side holds it back.
// After reset and after every register write, input is held off while the
// frame-start accumulator and uniform-copy decision are recomputed.
// The line store is not cleared; reset clears counters, flags and configuration registers.

module binary_image_horizontal_shear
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [7:0]                            s_axis_tdata,   // [0] pixel_in
    input  logic                                  s_axis_tuser,   // [0] kind
    // output stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [31:0]                           m_axis_tdata,   // [0] pixel_out,
                                                                  // [12:1] out_col,
                                                                  // [24:13] out_row
    output logic                                  m_axis_tlast,   // row_end
    output logic                                  m_axis_tuser,   // [0] frame_end
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [bihs_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bihs_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int SRC_W = bihs_pkg::SHIFT_W + 1;

    // configuration
    logic [bihs_pkg::SIZE_W-1:0]          width_reg;
    logic [bihs_pkg::SIZE_W-1:0]          height_reg;
    logic signed [bihs_pkg::SHEAR_W-1:0]  shear_reg;
    logic signed [bihs_pkg::ORIGIN_W-1:0] origin_reg;
    logic                                 background_reg;
    logic [1:0]                           settle_reg;
    logic [1:0]                           settle_next;

    logic [bihs_pkg::COL_W-1:0]           w_m1;
    logic [bihs_pkg::ROW_W-1:0]           h_m1;
    bihs_pkg::frame_calc_t                calc;

    // input side state
    logic                                 bank_reg;
    logic                                 bank_next;
    logic [bihs_pkg::COL_W-1:0]           col_reg;
    logic [bihs_pkg::COL_W-1:0]           col_next;
    logic [bihs_pkg::ROW_W-1:0]           row_reg;
    logic [bihs_pkg::ROW_W-1:0]           row_next;
    logic signed [bihs_pkg::ACC_W-1:0]    acc_reg;
    logic signed [bihs_pkg::ACC_W-1:0]    acc_next;
    logic                                 uniform_reg;
    logic                                 uniform_next;

    // pending row
    logic                                 pend_valid_reg;
    logic                                 pend_valid_next;
    logic signed [bihs_pkg::SHIFT_W-1:0]  pend_shift_reg;
    logic signed [bihs_pkg::SHIFT_W-1:0]  pend_shift_next;
    logic [bihs_pkg::ROW_W-1:0]           pend_row_reg;
    logic [bihs_pkg::ROW_W-1:0]           pend_row_next;
    logic                                 pend_last_reg;
    logic                                 pend_last_next;
    logic [bihs_pkg::COL_W-1:0]           drain_col_reg;
    logic [bihs_pkg::COL_W-1:0]           drain_col_next;

    // output stage
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic                                 out_inrange_reg;
    logic [bihs_pkg::COL_W-1:0]           out_col_reg;
    logic [bihs_pkg::ROW_W-1:0]           out_row_reg;
    logic                                 out_rend_reg;
    logic                                 out_fend_reg;

    // line store
    logic                                 line_mem [0:2*bihs_pkg::MAX_WIDTH-1];
    logic                                 rd_data_reg;
    logic [bihs_pkg::ADDR_W-1:0]          rd_addr;
    logic [bihs_pkg::ADDR_W-1:0]          wr_addr;
    logic                                 rd_en;
    logic                                 wr_en;

    // datapath
    logic                                 accept;
    logic                                 frame_start;
    logic                                 row_done;
    logic                                 last_row;
    logic                                 rend;
    logic signed [SRC_W-1:0]              src;
    logic                                 in_range;
    logic signed [bihs_pkg::ACC_W-1:0]    acc_cur;
    logic                                 uniform_cur;

    // ---------------------------------------------------------------
    // Configuration registers; restart the settle count on every write
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= bihs_pkg::SIZE_W'(bihs_pkg::MAX_WIDTH);
            height_reg     <= bihs_pkg::SIZE_W'(bihs_pkg::MAX_HEIGHT);
            shear_reg      <= '0;
            origin_reg     <= '0;
            background_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bihs_pkg::REG_IMAGE_WIDTH:  width_reg      <= cfg_data[bihs_pkg::SIZE_W-1:0];
                bihs_pkg::REG_IMAGE_HEIGHT: height_reg     <= cfg_data[bihs_pkg::SIZE_W-1:0];
                bihs_pkg::REG_SHEAR:        shear_reg      <= cfg_data[bihs_pkg::SHEAR_W-1:0];
                bihs_pkg::REG_ORIGIN:       origin_reg     <= cfg_data[bihs_pkg::ORIGIN_W-1:0];
                bihs_pkg::REG_BACKGROUND:   background_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    assign settle_next = cfg_we ? bihs_pkg::SETTLE_CYCLES :
                         (settle_reg != 2'd0) ? settle_reg - 2'd1 : settle_reg;

    assign w_m1 = bihs_pkg::size_m1(width_reg);
    assign h_m1 = bihs_pkg::size_m1(height_reg);

    // start accumulator and uniform-copy flag, tracked from the registers
    bihs_frame_calc u_frame_calc
    (
        .clk    (clk),
        .shear  (shear_reg),
        .origin (origin_reg),
        .h_m1   (h_m1),
        .calc   (calc)
    );

    // ---------------------------------------------------------------
    // Handshake: take an item unless settling or a result is stuck
    // ---------------------------------------------------------------
    assign s_axis_tready = (settle_reg == 2'd0) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------
    // Drain side: one pixel of the pending row per accepted item
    // ---------------------------------------------------------------
    assign src      = SRC_W'($signed({1'b0, drain_col_reg})) - SRC_W'(pend_shift_reg);
    assign in_range = !src[SRC_W-1] &&
                      (src[SRC_W-2:0] <= (SRC_W-1)'(w_m1));
    assign rend     = (drain_col_reg >= w_m1);
    assign rd_en    = accept && pend_valid_reg;
    // read from the bank not being filled
    assign rd_addr  = {~bank_reg, src[bihs_pkg::COL_W-1:0]};

    // ---------------------------------------------------------------
    // Fill side: write the pixel, advance column and row
    // ---------------------------------------------------------------
    assign wr_en       = accept && (s_axis_tuser == bihs_pkg::KIND_PIXEL);
    assign wr_addr     = {bank_reg, col_reg};
    assign frame_start = (col_reg == '0) && (row_reg == '0);
    assign row_done    = wr_en && (col_reg >= w_m1);
    assign last_row    = (row_reg >= h_m1);
    // at frame start take the freshly computed values
    assign acc_cur     = frame_start ? calc.acc_start : acc_reg;
    assign uniform_cur = frame_start ? calc.uniform : uniform_reg;

    always_comb
    begin
        bank_next       = bank_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        acc_next        = acc_reg;
        uniform_next    = uniform_reg;
        pend_valid_next = pend_valid_reg;
        pend_shift_next = pend_shift_reg;
        pend_row_next   = pend_row_reg;
        pend_last_next  = pend_last_reg;
        drain_col_next  = drain_col_reg;

        if (rd_en)
        begin
            if (rend)
            begin
                pend_valid_next = 1'b0;
                drain_col_next  = '0;
            end
            else
            begin
                drain_col_next = drain_col_reg + bihs_pkg::COL_W'(1);
            end
        end

        if (wr_en)
        begin
            acc_next     = acc_cur;
            uniform_next = uniform_cur;
            if (row_done)
            begin
                // hand the finished bank over; any undrained pixels are dropped
                pend_valid_next = 1'b1;
                pend_shift_next = uniform_cur ? '0 :
                                  acc_cur[bihs_pkg::ACC_W-1:bihs_pkg::ACC_FRAC];
                pend_row_next   = row_reg;
                pend_last_next  = last_row;
                drain_col_next  = '0;
                acc_next        = acc_cur + {{(bihs_pkg::ACC_W-bihs_pkg::SHEAR_W-1)
                                              {shear_reg[bihs_pkg::SHEAR_W-1]}},
                                             shear_reg, 1'b0};
                bank_next       = ~bank_reg;
                col_next        = '0;
                row_next        = last_row ? '0 : row_reg + bihs_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + bihs_pkg::COL_W'(1);
            end
        end
    end

    // output register: load on a read, drop once transferred
    assign out_valid_next = rd_en ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg     <= bihs_pkg::SETTLE_CYCLES;
            bank_reg       <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            uniform_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_row_reg   <= '0;
            pend_last_reg  <= 1'b0;
            drain_col_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            settle_reg     <= settle_next;
            bank_reg       <= bank_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            uniform_reg    <= uniform_next;
            pend_valid_reg <= pend_valid_next;
            pend_row_reg   <= pend_row_next;
            pend_last_reg  <= pend_last_next;
            drain_col_reg  <= drain_col_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        pend_shift_reg <= pend_shift_next;
        if (rd_en)
        begin
            out_inrange_reg <= in_range;
            out_col_reg     <= drain_col_reg;
            out_row_reg     <= pend_row_reg;
            out_rend_reg    <= rend;
            out_fend_reg    <= rend && pend_last_reg;
        end
    end

    // line store: two banks, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wr_addr] <= s_axis_tdata[0];
        if (rd_en)
            rd_data_reg <= line_mem[rd_addr];
    end

    // ---------------------------------------------------------------
    // Output ports
    // ---------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0000000, out_row_reg, out_col_reg,
                            out_inrange_reg ? rd_data_reg : background_reg};
    assign m_axis_tlast  = out_rend_reg;
    assign m_axis_tuser  = out_fend_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `BIHS_ASSERT_IMP(a_settle_blocks, settle_reg != 2'd0, !s_axis_tready)
    `BIHS_ASSERT_IMP(a_frame_end_on_row_end, out_valid_reg && out_fend_reg, out_rend_reg)
    `BIHS_ASSERT_IMP(a_row_end_col, out_valid_reg && out_rend_reg, out_col_reg == w_m1)
    `BIHS_ASSERT_NXT(a_drain_continues, rd_en && !rend, pend_valid_reg)

endmodule
